// File: rtl/wireworld_generation_step_defines.svh
// assertion macros shared by the wireworld generation step rtl
// expects aclk and aresetn in the scope of each use
`ifndef WIREWORLD_GENERATION_STEP_DEFINES_SVH
`define WIREWORLD_GENERATION_STEP_DEFINES_SVH

// same-cycle implication, off during reset
`define WW_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define WW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ww_pkg.sv
// shared types and constants of the wireworld generation step
// no dependencies
package ww_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    // cell codes
    localparam logic [1:0] CELL_EMPTY = 2'd0;
    localparam logic [1:0] CELL_HEAD  = 2'd1;
    localparam logic [1:0] CELL_TAIL  = 2'd2;
    localparam logic [1:0] CONDUCTOR  = 2'd3;

    localparam int CELL_W     = 2;
    localparam int COLUMN_W   = 3 * CELL_W;  // one window column: upper, middle, lower
    localparam int LINE_W     = 2 * CELL_W;  // one line store entry: upper, middle
    localparam int DIM_REG_W  = 8;
    localparam int CELL_IDX_W = 7;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DIM_REG_W-1:0] ROW_LENGTH_RST = 8'd90;
    localparam logic [DIM_REG_W-1:0] ROW_COUNT_RST  = 8'd70;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_LENGTH = 1'b0,
        REG_ROW_COUNT  = 1'b1
    } cfg_index_t;

    typedef logic [COLUMN_W-1:0] column_t;

endpackage

// File: rtl/wireworld_generation_step.sv
// wireworld generation step: takes one generation in raster order and streams out the
// next one. one cell item is taken per clock cycle while s_axis_tready is high, with no
// gaps between frames; the output register frees the input side whenever the result is
// taken or the register is empty. results lag the input by one row plus one cell: after
// reset the first w+1 items give no result, every later item gives exactly one in the
// cycle after it is taken. the line store memory is read one column ahead, so its
// registered read keeps pace with the column counter. the line store needs no clearing
// pass; until a full row has gone by its contents only reach border cells, which are
// always empty. row_length and row_count are used saturated to 3..MAX_WIDTH and
// 3..MAX_HEIGHT and should only be written while no item is in flight.
// depends on ww_pkg, ww_line_store, ww_column_cell, ww_rule
`include "wireworld_generation_step_defines.svh"
module wireworld_generation_step #(
    parameter int MAX_WIDTH  = ww_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ww_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [ww_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ww_pkg::DIM_REG_W-1:0]      cfg_wr_data,
    // input cells
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [1:0] cell_state
    // next-generation cells
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [1:0] next_state,
                                                              // [8:2] cell_row,
                                                              // [15:9] cell_col
    output logic                              m_axis_tlast    // frame_last
);
    import ww_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CW    = COL_W + 1;
    localparam int RW    = ROW_W + 1;

    // configuration registers
    logic [DIM_REG_W-1:0] row_length_reg, row_length_next;
    logic [DIM_REG_W-1:0] row_count_reg, row_count_next;

    always_comb begin
        row_length_next = row_length_reg;
        row_count_next  = row_count_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_ROW_LENGTH: row_length_next = cfg_wr_data;
                REG_ROW_COUNT:  row_count_next  = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= ROW_LENGTH_RST;
            row_count_reg  <= ROW_COUNT_RST;
        end else begin
            row_length_reg <= row_length_next;
            row_count_reg  <= row_count_next;
        end
    end

    // saturated dimensions
    logic [31:0]   w_full, h_full;
    logic [CW-1:0] w;
    logic [RW-1:0] h;

    always_comb begin
        if (row_length_reg < 8'd3) begin
            w_full = 32'd3;
        end else if (32'(row_length_reg) > 32'(MAX_WIDTH)) begin
            w_full = 32'(MAX_WIDTH);
        end else begin
            w_full = 32'(row_length_reg);
        end
        if (row_count_reg < 8'd3) begin
            h_full = 32'd3;
        end else if (32'(row_count_reg) > 32'(MAX_HEIGHT)) begin
            h_full = 32'(MAX_HEIGHT);
        end else begin
            h_full = 32'(row_count_reg);
        end
    end

    assign w = w_full[CW-1:0];
    assign h = h_full[RW-1:0];

    // handshake
    logic m_valid_reg, m_valid_next;
    logic s_acc;
    logic produce;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // input position counters
    logic [COL_W-1:0] in_col_reg, in_col_next, col_adv;
    logic [ROW_W-1:0] in_row_reg, in_row_next, row_adv;
    logic [CW-1:0]    col_inc;
    logic [RW-1:0]    row_inc;
    logic             col_wrap;
    logic             warmup_done_reg, warmup_done_next;

    always_comb begin
        col_inc  = {1'b0, in_col_reg} + CW'(1);
        row_inc  = {1'b0, in_row_reg} + RW'(1);
        col_wrap = (col_inc >= w);
        col_adv  = col_wrap ? '0 : col_inc[COL_W-1:0];
        if (col_wrap) begin
            row_adv = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            row_adv = in_row_reg;
        end
        in_col_next      = s_acc ? col_adv : in_col_reg;
        in_row_next      = s_acc ? row_adv : in_row_reg;
        warmup_done_next = warmup_done_reg ||
                           (s_acc && in_row_reg != '0 && in_col_reg != '0);
        produce          = s_acc && warmup_done_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            warmup_done_reg <= 1'b0;
        end else begin
            in_col_reg      <= in_col_next;
            in_row_reg      <= in_row_next;
            warmup_done_reg <= warmup_done_next;
        end
    end

    // line store, read one column ahead of the item that will use it
    logic [CELL_W-1:0] x;
    logic [LINE_W-1:0] line_rd;
    column_t           new_col;
    column_t           centre_col, left_col;

    assign x       = s_axis_tdata[CELL_W-1:0];
    assign new_col = {x, line_rd};

    ww_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s_acc),
        .wr_addr (in_col_reg),
        .wr_data ({x, line_rd[LINE_W-1:CELL_W]}),
        .rd_addr (in_col_next),
        .rd_data (line_rd)
    );

    // window columns
    ww_column_cell u_centre_cell (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s_acc),
        .col_in   (new_col),
        .col_q    (centre_col)
    );

    ww_column_cell u_left_cell (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (s_acc),
        .col_in   (centre_col),
        .col_q    (left_col)
    );

    logic [CELL_W-1:0] rule_state;

    ww_rule u_rule (
        .left_col   (left_col),
        .centre_col (centre_col),
        .right_col  (new_col),
        .next_state (rule_state)
    );

    // position of the centre cell
    logic [CW-1:0]     out_col;
    logic [RW-1:0]     out_row, row_ext, back;
    logic              on_border;
    logic              last_cell;
    logic [CELL_W-1:0] result_state;

    always_comb begin
        row_ext = {1'b0, in_row_reg};
        if (in_col_reg == '0) begin
            out_col = w - CW'(1);
            back    = RW'(2);
        end else begin
            out_col = {1'b0, in_col_reg} - CW'(1);
            back    = RW'(1);
        end
        out_row = (row_ext >= back) ? row_ext - back : row_ext + h - back;
        on_border = (out_row == '0) || (out_row >= h - RW'(1)) ||
                    (out_col == '0) || (out_col >= w - CW'(1));
        last_cell = (out_row == h - RW'(1)) && (out_col == w - CW'(1));
        result_state = on_border ? CELL_EMPTY : rule_state;
    end

    // output register
    logic [CELL_W-1:0]     next_state_reg;
    logic [CELL_IDX_W-1:0] cell_row_reg, cell_col_reg;
    logic                  frame_last_reg;

    always_comb begin
        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            next_state_reg <= result_state;
            cell_row_reg   <= CELL_IDX_W'(out_row);
            cell_col_reg   <= CELL_IDX_W'(out_col);
            frame_last_reg <= last_cell;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {cell_col_reg, cell_row_reg, next_state_reg};
    assign m_axis_tlast  = frame_last_reg;

    `WW_ASSERT_IMPLIES(a_no_result_before_warm, m_valid_reg, warmup_done_reg,
        "result shown before the first full row plus one cell")
    `WW_ASSERT_NEXT(a_result_follows_item, produce, m_valid_reg,
        "item past warm-up gave no result")
    `WW_ASSERT_NEXT(a_column_advances, s_acc, in_col_reg != $past(in_col_reg),
        "column counter did not move on an accepted item")

endmodule

// File: rtl/ww_line_store.sv
// two line stores packed into one memory, one entry per grid column
// depends on ww_pkg
module ww_line_store #(
    parameter int MAX_WIDTH = ww_pkg::MAX_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [ww_pkg::LINE_W-1:0]    wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [ww_pkg::LINE_W-1:0]    rd_data
);
    import ww_pkg::*;

    logic [LINE_W-1:0] mem [MAX_WIDTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ww_column_cell.sv
// one column stage of the 3x3 window, shifts toward its neighbor on each item
// depends on ww_pkg
module ww_column_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  ww_pkg::column_t col_in,
    output ww_pkg::column_t col_q
);
    import ww_pkg::*;

    column_t col_reg;
    column_t col_next;

    always_comb begin
        col_next = shift_en ? col_in : col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_q = col_reg;

endmodule

// File: rtl/ww_rule.sv
// wireworld transition for the centre cell of a 3x3 window
// depends on ww_pkg
module ww_rule (
    input  ww_pkg::column_t           left_col,
    input  ww_pkg::column_t           centre_col,
    input  ww_pkg::column_t           right_col,
    output logic [ww_pkg::CELL_W-1:0] next_state
);
    import ww_pkg::*;

    logic [7:0]        head_bits;
    logic [3:0]        heads;
    logic [CELL_W-1:0] cur;

    always_comb begin
        head_bits[0] = (left_col[1:0]   == CELL_HEAD);
        head_bits[1] = (left_col[3:2]   == CELL_HEAD);
        head_bits[2] = (left_col[5:4]   == CELL_HEAD);
        head_bits[3] = (centre_col[1:0] == CELL_HEAD);
        head_bits[4] = (centre_col[5:4] == CELL_HEAD);
        head_bits[5] = (right_col[1:0]  == CELL_HEAD);
        head_bits[6] = (right_col[3:2]  == CELL_HEAD);
        head_bits[7] = (right_col[5:4]  == CELL_HEAD);
        heads = '0;
        for (int i = 0; i < 8; i++) begin
            heads = heads + 4'(head_bits[i]);
        end
    end

    assign cur = centre_col[3:2];

    always_comb begin
        unique case (cur)
            CELL_HEAD: next_state = CELL_TAIL;
            CELL_TAIL: next_state = CONDUCTOR;
            CONDUCTOR: next_state = (heads == 4'd1 || heads == 4'd2) ? CELL_HEAD
                                                                     : CONDUCTOR;
            default:   next_state = CELL_EMPTY;
        endcase
    end

endmodule

// File: tb/sv/wireworld_step_checker.sv
`timescale 1ns / 100ps
// checker for the wireworld generation step: follows the accepted cell items, predicts
// the next-generation items with its own copy of the line stores and compares them
// depends on ww_pkg
module wireworld_step_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ww_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ww_pkg::DIM_REG_W-1:0]   cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [1:0] cell_state
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [15:0]                    m_axis_tdata,   // [1:0] next_state,
                                                           // [8:2] cell_row,
                                                           // [15:9] cell_col
    input  logic                           m_axis_tlast,   // frame_last
    output int                             mismatches,
    output int                             outstanding,
    output int                             cells_checked,
    output int                             frame_ends
);
    import ww_pkg::*;

    typedef struct packed {
        logic [1:0] next_state;
        logic [6:0] cell_row;
        logic [6:0] cell_col;
        logic       frame_last;
    } gen_cell_t;

    gen_cell_t expected_cells[$];
    gen_cell_t got, want;

    logic [1:0]           line_two_up [0:MAX_WIDTH_DEF-1];
    logic [1:0]           line_one_up [0:MAX_WIDTH_DEF-1];
    logic [11:0]          window_q;
    int unsigned          col_q, row_q;
    logic                 warm_q;
    logic [DIM_REG_W-1:0] row_length_q, row_count_q;
    int                   i;

    function automatic int unsigned dim_in_use(input logic [DIM_REG_W-1:0] v,
                                               input int unsigned limit);
        if (v < 3) return 3;
        if (v > limit) return limit;
        return 32'(v);
    endfunction

    task automatic predict_next_cell(input logic [1:0] cell_val);
        int unsigned w, h, col, row, back, heads, out_row, out_col;
        int          k;
        logic [1:0]  up, mid;
        logic [5:0]  newcol, left_col, centre_col;
        gen_cell_t   res;
        w = dim_in_use(row_length_q, MAX_WIDTH_DEF);
        h = dim_in_use(row_count_q, MAX_HEIGHT_DEF);
        col = col_q;
        row = row_q;
        up = CELL_EMPTY;
        mid = CELL_EMPTY;
        if (col < MAX_WIDTH_DEF) begin
            up = line_two_up[col];
            mid = line_one_up[col];
        end
        // window column: upper in the low bits, the new cell on top
        newcol = {cell_val, mid, up};
        left_col = window_q[11:6];
        centre_col = window_q[5:0];
        if (!warm_q && row >= 1 && col >= 1)
            warm_q = 1'b1;
        if (warm_q) begin
            if (col == 0) begin
                out_col = w - 1;
                back = 2;
            end else begin
                out_col = col - 1;
                back = 1;
            end
            out_row = (row >= back) ? row - back : row + h - back;
            heads = 0;
            for (k = 0; k < 3; k++) begin
                if (left_col[2*k +: 2] == CELL_HEAD) heads++;
                if (newcol[2*k +: 2] == CELL_HEAD) heads++;
                if (k != 1 && centre_col[2*k +: 2] == CELL_HEAD) heads++;
            end
            case (centre_col[3:2])
                CELL_HEAD: res.next_state = CELL_TAIL;
                CELL_TAIL: res.next_state = CONDUCTOR;
                CONDUCTOR: res.next_state = (heads == 1 || heads == 2) ? CELL_HEAD
                                                                       : CONDUCTOR;
                default:   res.next_state = CELL_EMPTY;
            endcase
            // the grid border never carries anything
            if (out_row == 0 || out_row >= h - 1 || out_col == 0 || out_col >= w - 1)
                res.next_state = CELL_EMPTY;
            res.cell_row = out_row[6:0];
            res.cell_col = out_col[6:0];
            res.frame_last = (out_row == h - 1 && out_col == w - 1);
            expected_cells.push_back(res);
        end
        if (col < MAX_WIDTH_DEF) begin
            line_two_up[col] = mid;
            line_one_up[col] = cell_val;
        end
        window_q = {centre_col, newcol};
        if (col + 1 >= w) begin
            col_q = 0;
            row_q = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_q = col + 1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_length_q = ROW_LENGTH_RST;
            row_count_q = ROW_COUNT_RST;
            window_q = '0;
            col_q = 0;
            row_q = 0;
            warm_q = 1'b0;
            for (i = 0; i < MAX_WIDTH_DEF; i++) begin
                line_two_up[i] = CELL_EMPTY;
                line_one_up[i] = CELL_EMPTY;
            end
            expected_cells.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_ROW_LENGTH)
                    row_length_q = cfg_wr_data;
                else if (cfg_index == REG_ROW_COUNT)
                    row_count_q = cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.next_state = m_axis_tdata[1:0];
                got.cell_row = m_axis_tdata[8:2];
                got.cell_col = m_axis_tdata[15:9];
                got.frame_last = m_axis_tlast;
                if (expected_cells.size() == 0) begin
                    $error("unexpected next-generation item: row %0d col %0d state %0d",
                           got.cell_row, got.cell_col, got.next_state);
                    mismatches++;
                end else begin
                    want = expected_cells.pop_front();
                    if (got.next_state !== want.next_state) begin
                        $error("next_state: expected %0d, got %0d",
                               want.next_state, got.next_state);
                        mismatches++;
                    end
                    if (got.cell_row !== want.cell_row) begin
                        $error("cell_row: expected %0d, got %0d", want.cell_row, got.cell_row);
                        mismatches++;
                    end
                    if (got.cell_col !== want.cell_col) begin
                        $error("cell_col: expected %0d, got %0d", want.cell_col, got.cell_col);
                        mismatches++;
                    end
                    if (got.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0d, got %0d",
                               want.frame_last, got.frame_last);
                        mismatches++;
                    end
                    cells_checked++;
                    if (want.frame_last) frame_ends++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_next_cell(s_axis_tdata[1:0]);
        end
        outstanding = expected_cells.size();
    end

endmodule

// File: tb/sv/wireworld_generation_step_tb.sv
`timescale 1ns / 100ps
// top of the wireworld generation step testbench: clock, reset, grid settings, the
// cell stream with its gaps and the receiver stalls; checking lives in the checker
// depends on ww_pkg, wireworld_generation_step and wireworld_step_checker
module wireworld_generation_step_tb;
    import ww_pkg::*;

    localparam int TOTAL_CELLS = 1050;
    localparam int FILL_CELLS  = 3 * MAX_WIDTH_DEF;   // one whole 128 x 3 frame

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_ROW_LENGTH;
    logic [DIM_REG_W-1:0]   cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;     // [1:0] cell_state
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;          // [1:0] next_state, [8:2] cell_row,
                                                   // [15:9] cell_col
    logic                   m_axis_tlast;          // frame_last

    int mismatches, outstanding, cells_checked, frame_ends;
    int cells_sent, burst_left, settings_used, rx_mode, rx_count, phase, k;
    logic [0:24][1:0] demo_grid;

    always #2 aclk = ~aclk;

    wireworld_generation_step dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    wireworld_step_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .cells_checked (cells_checked),
        .frame_ends    (frame_ends)
    );

    // the receiver redraws its stall style each time rx_count wraps
    always @(negedge aclk) begin
        if (rx_count == 0)
            rx_mode = $urandom_range(0, 3);
        rx_count = (rx_count + 1) % 150;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            2:       m_axis_tready <= ((rx_count % 7) >= 3);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic logic [1:0] random_cell();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3) return CELL_EMPTY;
        if (r < 7) return CELL_HEAD;
        if (r < 10) return CELL_TAIL;
        return CONDUCTOR;
    endfunction

    function automatic logic [DIM_REG_W-1:0] random_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'd3;
        if (r == 1) return 8'd128;
        if (r == 2) return DIM_REG_W'($urandom_range(0, 255));
        return DIM_REG_W'($urandom_range(3, 10));
    endfunction

    // called and left at a falling edge
    task automatic send_cell(input logic [1:0] cell_val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, cell_val};
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        cells_sent++;
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        // stay idle before the next settings
        repeat (8) @(negedge aclk);
    endtask

    task automatic set_grid(input logic [DIM_REG_W-1:0] len, input logic [DIM_REG_W-1:0] cnt);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_ROW_LENGTH;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_index <= REG_ROW_COUNT;
        cfg_wr_data <= cnt;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // both registers out of range: saturates to 128 x 3; one full frame writes
        // every line store entry, so later width changes never read an unwritten entry
        set_grid(8'd255, 8'd0);
        repeat (FILL_CELLS) send_cell(random_cell());
        pause_until_drained();

        // 5x5 frame from row 0 col 0: heads, tails, empties and conductors
        // with one to four neighboring heads
        set_grid(8'd5, 8'd5);
        demo_grid = {CONDUCTOR,  CELL_HEAD,  CELL_HEAD,  CELL_EMPTY, CONDUCTOR,
                     CELL_HEAD,  CONDUCTOR,  CELL_TAIL,  CONDUCTOR,  CELL_EMPTY,
                     CELL_EMPTY, CELL_HEAD,  CONDUCTOR,  CELL_HEAD,  CELL_TAIL,
                     CONDUCTOR,  CONDUCTOR,  CELL_EMPTY, CONDUCTOR,  CELL_HEAD,
                     CELL_TAIL,  CELL_EMPTY, CELL_EMPTY, CELL_HEAD,  CONDUCTOR};
        for (k = 0; k < 25; k++)
            send_cell(demo_grid[k]);
        pause_until_drained();

        // settings change mid-frame, counters keep running
        phase = 0;
        while (cells_sent < TOTAL_CELLS) begin
            case (phase)
                0:       set_grid(8'd3, 8'd3);
                1:       set_grid(8'd128, 8'd128);
                2:       set_grid(8'd2, 8'd255);
                3:       set_grid(8'd129, 8'd1);
                default: set_grid(random_dim(), random_dim());
            endcase
            repeat ($urandom_range(12, 60)) send_cell(random_cell());
            pause_until_drained();
            phase++;
        end
        repeat (24) @(negedge aclk);

        $display("%0d cells fed under %0d grid settings, saturated and limit sizes included",
                 cells_sent, settings_used);
        $display("%0d next-generation cells compared, %0d of them closing a frame",
                 cells_checked, frame_ends);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
